// ===== hdl/matrix_mul_add_noise_mod_q_core_assert.svh =====
// Assertion macros shared by the checker files of the matrix multiply-add core.
`ifndef MATRIX_MUL_ADD_NOISE_MOD_Q_CORE_ASSERT_SVH
`define MATRIX_MUL_ADD_NOISE_MOD_Q_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MMANQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MMANQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mmanq_pkg.sv =====
// Shared constants, types and codes of the matrix multiply-add core.
package mmanq_pkg;

  // Matrix dimensions: S is OUTER x INNER, B is INNER x OUTER, E is OUTER x OUTER
  localparam int INNER_DIM = 752;
  localparam int OUTER_DIM = 8;

  // Field widths
  localparam int VALUE_W   = 16;
  localparam int IDX_W     = 10;
  localparam int Q_W       = 15;
  localparam int OUT_IDX_W = 3;
  localparam int MODE_W    = 2;

  // Store geometry
  localparam int WIDE_DEPTH  = INNER_DIM * OUTER_DIM;
  localparam int NOISE_DEPTH = OUTER_DIM * OUTER_DIM;
  localparam int WIDE_AW     = (WIDE_DEPTH > 1) ? $clog2(WIDE_DEPTH) : 1;
  localparam int NOISE_AW    = (NOISE_DEPTH > 1) ? $clog2(NOISE_DEPTH) : 1;

  // Counter widths
  localparam int J_W = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
  localparam int O_W = (OUTER_DIM > 1) ? $clog2(OUTER_DIM) : 1;

  // Stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Item kinds carried on in_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_WR_B    = 2'd0,
    MODE_WR_S    = 2'd1,
    MODE_WR_E    = 2'd2,
    MODE_COMPUTE = 2'd3
  } mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  // Tag that travels with each memory read through the MAC pipeline
  typedef struct packed {
    logic           vld;   // read slot carries a product
    logic           first; // first product of a dot product
    logic           last;  // last product of a dot product
    logic           fin;   // last product of the whole compute run
    logic [O_W-1:0] row;
    logic [O_W-1:0] col;
  } tag_t;

endpackage

// ===== hdl/mmanq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mmanq_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mmanq_seq.sv =====
// Read sequencer: walks row, column and inner index and issues store reads.
module mmanq_seq
  import mmanq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                adv,
  input  logic                mac_busy,
  output logic                idle,
  output logic [WIDE_AW-1:0]  s_raddr,
  output logic [WIDE_AW-1:0]  b_raddr,
  output logic [NOISE_AW-1:0] e_raddr,
  output tag_t                issue_tag
);

  seq_state_t     state_r, state_nxt;
  logic [O_W-1:0] r_r, r_nxt;
  logic [O_W-1:0] c_r, c_nxt;
  logic [J_W-1:0] j_r, j_nxt;
  logic           j_end, c_end, r_end;

  assign j_end = (j_r == J_W'(INNER_DIM - 1));
  assign c_end = (c_r == O_W'(OUTER_DIM - 1));
  assign r_end = (r_r == O_W'(OUTER_DIM - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_RUN;
      ST_RUN:   if (adv && j_end && c_end && r_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!mac_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs: read addresses and the tag of the current read slot
  always_comb begin
    idle            = (state_r == ST_IDLE);
    s_raddr         = WIDE_AW'(int'(r_r) * INNER_DIM + int'(j_r));
    b_raddr         = WIDE_AW'(int'(j_r) * OUTER_DIM + int'(c_r));
    e_raddr         = NOISE_AW'(int'(r_r) * OUTER_DIM + int'(c_r));
    issue_tag.vld   = (state_r == ST_RUN);
    issue_tag.first = (j_r == '0);
    issue_tag.last  = j_end;
    issue_tag.fin   = j_end && c_end && r_end;
    issue_tag.row   = r_r;
    issue_tag.col   = c_r;
  end

  // index counters: inner index fastest, then column, then row
  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    j_nxt = j_r;
    priority if (start) begin
      r_nxt = '0;
      c_nxt = '0;
      j_nxt = '0;
    end else if (state_r == ST_RUN && adv) begin
      if (j_end) begin
        j_nxt = '0;
        if (c_end) begin
          c_nxt = '0;
          r_nxt = r_end ? '0 : r_r + 1'b1;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

// ===== hdl/mmanq_mac.sv =====
// Multiply-accumulate pipeline with the result output register.
module mmanq_mac
  import mmanq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  tag_t                 issue_tag,
  input  logic [VALUE_W-1:0]   s_data,
  input  logic [VALUE_W-1:0]   b_data,
  input  logic [VALUE_W-1:0]   e_data,
  output logic                 adv,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] out_row,
  output logic [OUT_IDX_W-1:0] out_col,
  output logic [Q_W-1:0]       out_result,
  output logic                 out_last
);

  tag_t                 tag1_r, tag2_r;
  logic [Q_W-1:0]       prod_r, prod_nxt;
  logic [Q_W-1:0]       e2_r;
  logic [Q_W-1:0]       acc_r, acc_nxt;
  logic [2*VALUE_W-1:0] full_prod;
  logic                 deliver;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_row_r, out_col_r;
  logic [Q_W-1:0]       out_result_r;
  logic                 out_last_r;

  // freeze everything only when a finished entry meets a full output register that out_ready does not drain
  assign deliver = tag2_r.vld && tag2_r.last;
  assign adv     = !(deliver && out_valid_r && !out_ready);
  assign busy    = tag1_r.vld || tag2_r.vld;

  // product stage: only the low bits survive the modulus
  assign full_prod = s_data * b_data;
  assign prod_nxt  = full_prod[Q_W-1:0];

  // accumulate stage: a new dot product starts from the noise entry
  assign acc_nxt = (tag2_r.first ? e2_r : acc_r) + prod_r;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (adv && deliver) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        tag1_r <= issue_tag;
        tag2_r <= tag1_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      e2_r   <= e_data[Q_W-1:0];
      if (tag2_r.vld) begin
        acc_r <= acc_nxt;
      end
      if (deliver) begin
        out_row_r    <= OUT_IDX_W'(tag2_r.row);
        out_col_r    <= OUT_IDX_W'(tag2_r.col);
        out_result_r <= acc_nxt;
        out_last_r   <= tag2_r.fin;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_result = out_result_r;
  assign out_last   = out_last_r;

endmodule

// ===== hdl/matrix_mul_add_noise_mod_q_core.sv =====
// Top level of the noise-added matrix multiply core, S*B + E modulo 2^15.
//
// Load items (in_tuser = write B, write S or write E) store one 16-bit element
// each and are taken one per cycle while no compute runs; a write with an
// out-of-range row or column is dropped. A compute item produces OUTER_DIM x
// OUTER_DIM results in row-major order, tlast on the final one. The S and B
// stores each have one read port, so one product is formed per cycle unless
// out_tready holds a finished result back. in_tready is low from the compute
// item until the pipeline has drained. The stores are not cleared at reset;
// every element read by a compute must have been written before.
module matrix_mul_add_noise_mod_q_core
  import mmanq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row[9:0], col[19:10], value[35:20], zero pad
  input  logic [MODE_W-1:0]      in_tuser,   // mode[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_row[2:0], out_col[5:3], result[20:6], zero pad
  output logic                   out_tlast
);

  logic                 in_acc, start, seq_idle, adv, mac_busy;
  logic [IDX_W-1:0]     wr_row, wr_col;
  logic [VALUE_W-1:0]   wr_value;
  mode_t                mode;
  logic                 b_we, s_we, e_we;
  logic [WIDE_AW-1:0]   b_waddr, s_waddr, s_raddr, b_raddr;
  logic [NOISE_AW-1:0]  e_waddr, e_raddr;
  logic [VALUE_W-1:0]   s_data, b_data, e_data;
  tag_t                 issue_tag;
  logic [OUT_IDX_W-1:0] res_row, res_col;
  logic [Q_W-1:0]       res_val;

  // input unpacking
  assign wr_row   = in_tdata[IDX_W-1:0];
  assign wr_col   = in_tdata[2*IDX_W-1:IDX_W];
  assign wr_value = in_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];
  assign mode     = mode_t'(in_tuser);

  assign in_tready = seq_idle;
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && (mode == MODE_COMPUTE);

  // write decode with range checks per matrix shape
  assign b_we = in_acc && (mode == MODE_WR_B) &&
                (int'(wr_row) < INNER_DIM) && (int'(wr_col) < OUTER_DIM);
  assign s_we = in_acc && (mode == MODE_WR_S) &&
                (int'(wr_row) < OUTER_DIM) && (int'(wr_col) < INNER_DIM);
  assign e_we = in_acc && (mode == MODE_WR_E) &&
                (int'(wr_row) < OUTER_DIM) && (int'(wr_col) < OUTER_DIM);

  assign b_waddr = WIDE_AW'(int'(wr_row) * OUTER_DIM + int'(wr_col));
  assign s_waddr = WIDE_AW'(int'(wr_row) * INNER_DIM + int'(wr_col));
  assign e_waddr = NOISE_AW'(int'(wr_row) * OUTER_DIM + int'(wr_col));

  // element stores
  mmanq_ram #(.WIDTH(VALUE_W), .DEPTH(WIDE_DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wr_value),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  mmanq_ram #(.WIDTH(VALUE_W), .DEPTH(WIDE_DEPTH)) u_s_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (wr_value),
    .re    (adv),
    .raddr (s_raddr),
    .rdata (s_data)
  );

  mmanq_ram #(.WIDTH(VALUE_W), .DEPTH(NOISE_DEPTH)) u_e_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (wr_value),
    .re    (adv),
    .raddr (e_raddr),
    .rdata (e_data)
  );

  // read sequencer
  mmanq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .adv       (adv),
    .mac_busy  (mac_busy),
    .idle      (seq_idle),
    .s_raddr   (s_raddr),
    .b_raddr   (b_raddr),
    .e_raddr   (e_raddr),
    .issue_tag (issue_tag)
  );

  // multiply-accumulate and output register
  mmanq_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_tag  (issue_tag),
    .s_data     (s_data),
    .b_data     (b_data),
    .e_data     (e_data),
    .adv        (adv),
    .busy       (mac_busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (res_row),
    .out_col    (res_col),
    .out_result (res_val),
    .out_last   (out_tlast)
  );

  // output packing
  assign out_tdata = {(OUT_TDATA_W - Q_W - 2*OUT_IDX_W)'(0), res_val, res_col, res_row};

endmodule

// ===== hdl/mmanq_props.sv =====
// Port-level checker for the matrix multiply-add core, bound to the top level.
`include "matrix_mul_add_noise_mod_q_core_assert.svh"

module mmanq_props
  import mmanq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [MODE_W-1:0]      in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // a stalled result stays offered
  `MMANQ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `MMANQ_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // accepting a compute item closes the input
  `MMANQ_ASSERT_NXT(a_busy_after_compute, in_tvalid && in_tready && in_tuser == MODE_COMPUTE, !in_tready, "input open during compute")

  // the marked result is the bottom-right entry
  `MMANQ_ASSERT_NOW(a_last_corner, out_tvalid && out_tlast, out_tdata[OUT_IDX_W-1:0] == OUT_IDX_W'(OUTER_DIM - 1) && out_tdata[2*OUT_IDX_W-1:OUT_IDX_W] == OUT_IDX_W'(OUTER_DIM - 1), "last mark on wrong entry")

endmodule

bind matrix_mul_add_noise_mod_q_core mmanq_props u_mmanq_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== dv/matrix_mul_add_noise_mod_q_core_tb.sv =====
// Testbench for the S*B + E modulo 2^15 matrix core: directed and random items, self-checking.
`timescale 1ns / 1ps

module matrix_mul_add_noise_mod_q_core_tb;
  import mmanq_pkg::*;

  // One result element of S*B + E
  typedef struct packed {
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic [Q_W-1:0]       sum;
    logic                 last;
  } sbe_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]      in_tuser = MODE_WR_B;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Mirror of the three element stores
  logic [VALUE_W-1:0] b_mat [WIDE_DEPTH];
  logic [VALUE_W-1:0] s_mat [WIDE_DEPTH];
  logic [VALUE_W-1:0] e_mat [NOISE_DEPTH];

  sbe_t pending_sbe [$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  matrix_mul_add_noise_mod_q_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Update the mirrored stores; a compute item queues all S*B + E entries
  task automatic mirror_item(input mode_t mode, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value);
    int unsigned acc;
    sbe_t        ent;
    case (mode)
      MODE_WR_B: begin
        if (row < INNER_DIM && col < OUTER_DIM) b_mat[row * OUTER_DIM + col] = value;
      end
      MODE_WR_S: begin
        if (row < OUTER_DIM && col < INNER_DIM) s_mat[row * INNER_DIM + col] = value;
      end
      MODE_WR_E: begin
        if (row < OUTER_DIM && col < OUTER_DIM) e_mat[row * OUTER_DIM + col] = value;
      end
      default: begin
        for (int r = 0; r < OUTER_DIM; r++) begin
          for (int c = 0; c < OUTER_DIM; c++) begin
            acc = 32'(e_mat[r * OUTER_DIM + c]);
            for (int j = 0; j < INNER_DIM; j++) begin
              acc += 32'(s_mat[r * INNER_DIM + j]) * 32'(b_mat[j * OUTER_DIM + c]);
            end
            ent.row  = r[OUT_IDX_W-1:0];
            ent.col  = c[OUT_IDX_W-1:0];
            ent.sum  = acc[Q_W-1:0];
            ent.last = (r == OUTER_DIM - 1) && (c == OUTER_DIM - 1);
            pending_sbe.push_back(ent);
          end
        end
      end
    endcase
  endtask

  // Send one item, with random idle cycles ahead of it
  task automatic send_item(input mode_t mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, value, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror_item(mode, row, col, value);
  endtask

  // Hold the input idle until every queued result has come out
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sbe.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Write every element of B, S and E, either random or one fixed value
  task automatic fill_stores(input bit use_random, input logic [VALUE_W-1:0] fixed);
    for (int j = 0; j < INNER_DIM; j++) begin
      for (int c = 0; c < OUTER_DIM; c++) begin
        send_item(MODE_WR_B, IDX_W'(j), IDX_W'(c),
                  use_random ? VALUE_W'($urandom_range(65535)) : fixed);
      end
    end
    for (int r = 0; r < OUTER_DIM; r++) begin
      for (int j = 0; j < INNER_DIM; j++) begin
        send_item(MODE_WR_S, IDX_W'(r), IDX_W'(j),
                  use_random ? VALUE_W'($urandom_range(65535)) : fixed);
      end
    end
    for (int r = 0; r < OUTER_DIM; r++) begin
      for (int c = 0; c < OUTER_DIM; c++) begin
        send_item(MODE_WR_E, IDX_W'(r), IDX_W'(c),
                  use_random ? VALUE_W'($urandom_range(65535)) : fixed);
      end
    end
  endtask

  // Every store written with random data, then one product
  task automatic test_full_load();
    fill_stores(1'b1, '0);
    send_item(MODE_COMPUTE, IDX_W'($urandom_range(1023)), IDX_W'($urandom_range(1023)),
              VALUE_W'($urandom_range(65535)));
    wait_for_results();
  endtask

  // All-ones stores give the largest operands; all-zero stores give zero
  task automatic test_fill_extremes();
    fill_stores(1'b0, 16'hFFFF);
    send_item(MODE_COMPUTE, 10'd0, 10'd0, 16'h0000);
    fill_stores(1'b0, 16'h0000);
    send_item(MODE_COMPUTE, 10'h3FF, 10'h3FF, 16'hFFFF);
    wait_for_results();
  endtask

  // Out-of-range writes must be dropped; corner indices must land
  task automatic test_index_bounds();
    send_item(MODE_WR_B, 10'd752, 10'd0, 16'h1234);
    send_item(MODE_WR_B, 10'h3FF, 10'd7, 16'hFFFF);
    send_item(MODE_WR_B, 10'd0, 10'd8, 16'hAAAA);
    send_item(MODE_WR_B, 10'd751, 10'h3FF, 16'h5555);
    send_item(MODE_WR_S, 10'd8, 10'd0, 16'h4321);
    send_item(MODE_WR_S, 10'h3FF, 10'd751, 16'hFFFF);
    send_item(MODE_WR_S, 10'd0, 10'd752, 16'h0F0F);
    send_item(MODE_WR_S, 10'd7, 10'h3FF, 16'hF0F0);
    send_item(MODE_WR_E, 10'd8, 10'd0, 16'h7777);
    send_item(MODE_WR_E, 10'd0, 10'd8, 16'h8888);
    send_item(MODE_WR_E, 10'h3FF, 10'h3FF, 16'hFFFF);
    send_item(MODE_WR_B, 10'd751, 10'd7, 16'hFFFF);
    send_item(MODE_WR_B, 10'd0, 10'd0, 16'h0000);
    send_item(MODE_WR_S, 10'd7, 10'd751, 16'h8000);
    send_item(MODE_WR_S, 10'd0, 10'd0, 16'h0001);
    send_item(MODE_WR_E, 10'd7, 10'd7, 16'h7FFF);
    send_item(MODE_WR_E, 10'd0, 10'd0, 16'hFFFF);
    send_item(MODE_COMPUTE, 10'h3FF, 10'h3FF, 16'hFFFF);
    wait_for_results();
  endtask

  // Random writes with a little out-of-range noise and a compute now and then
  task automatic test_random_mix();
    mode_t             mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VALUE_W-1:0] value;
    int                pick;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       set_idling(6, 59);
        1:       set_idling(59, 6);
        default: set_idling(0, 0);
      endcase
      for (int k = 0; k < 57; k++) begin
        case ($urandom_range(7))
          0:       value = 16'h0000;
          1:       value = 16'hFFFF;
          default: value = VALUE_W'($urandom_range(65535));
        endcase
        pick = $urandom_range(99);
        if (k % 28 == 27) begin
          send_item(MODE_COMPUTE, IDX_W'($urandom_range(1023)),
                    IDX_W'($urandom_range(1023)), value);
          // hold off the sender until the whole product has drained
          if (phase == 1 && k == 27) wait_for_results();
        end else if (pick < 10) begin
          mode = mode_t'($urandom_range(2));
          send_item(mode, IDX_W'($urandom_range(1023)), IDX_W'($urandom_range(1023)), value);
        end else begin
          mode = mode_t'($urandom_range(2));
          case (mode)
            MODE_WR_B: begin
              row = IDX_W'($urandom_range(INNER_DIM - 1));
              col = IDX_W'($urandom_range(OUTER_DIM - 1));
            end
            MODE_WR_S: begin
              row = IDX_W'($urandom_range(OUTER_DIM - 1));
              col = IDX_W'($urandom_range(INNER_DIM - 1));
            end
            default: begin
              row = IDX_W'($urandom_range(OUTER_DIM - 1));
              col = IDX_W'($urandom_range(OUTER_DIM - 1));
            end
          endcase
          send_item(mode, row, col, value);
        end
      end
    end
    wait_for_results();
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    sbe_t got;
    sbe_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.row  = out_tdata[2:0];
      got.col  = out_tdata[5:3];
      got.sum  = out_tdata[20:6];
      got.last = out_tlast;
      if (pending_sbe.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected item row %0d col %0d sum %h last %b",
                   got.row, got.col, got.sum, got.last);
        end
      end else begin
        want = pending_sbe.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.sum !== want.sum || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: exp row %0d col %0d sum %h last %b, got row %0d col %0d sum %h last %b",
                     want.row, want.col, want.sum, want.last,
                     got.row, got.col, got.sum, got.last);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(6, 59);
    test_full_load();
    set_idling(59, 6);
    test_fill_extremes();
    set_idling(0, 0);
    test_index_bounds();
    test_random_mix();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_sbe.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
